[hw/rtl/assert_macros.svh]
// assertion helpers used by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tspc_pkg.sv]
package tspc_pkg;

  // angle and speed scaling
  localparam int ANGLE_FRACTION_BITS = 4;
  localparam int WRAP_COUNT_BITS     = 8;
  localparam int SPEED_FRAC          = 4;

  // field and state widths
  localparam int HEAD_W     = 13;
  localparam int TGT_W      = 17;
  localparam int STEP_W     = 4;
  localparam int SPEED_W    = 12;
  localparam int PEAK_W     = 13;
  localparam int LIMIT_W    = 8;
  localparam int WHEEL_W    = 9;
  localparam int TURN_OUT_W = 21;
  localparam int CFG_IDX_W  = 1;

  // angle constants in fractional degree units
  localparam int DEG1   = 1 << ANGLE_FRACTION_BITS;
  localparam int DEG90  = 90 << ANGLE_FRACTION_BITS;
  localparam int DEG180 = 180 << ANGLE_FRACTION_BITS;
  localparam int DEG340 = 340 << ANGLE_FRACTION_BITS;
  localparam int DEG360 = 360 << ANGLE_FRACTION_BITS;

  // internal arithmetic width: wrap count times a full turn plus two headings, with margin
  localparam int DEG360_W = $clog2(DEG360 + 1) + 1;
  localparam int TURN_W   = WRAP_COUNT_BITS + DEG360_W + 2;
  localparam int CMP_W    = TURN_W + SPEED_FRAC + 4;

  // speed limits in whole rpm
  localparam int LIMIT_HI  = 200;
  localparam int LIMIT_MID = 50;
  localparam int LIMIT_LO  = 30;

  // register reset values
  localparam int STEP_RESET = 2;
  localparam int PEAK_RESET = -(1 << SPEED_FRAC);

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ANGLE = 1'b0,
    REG_RAMP_STEP    = 1'b1
  } cfg_idx_t;

  // controller state carried from item to item
  typedef struct packed {
    logic [HEAD_W-1:0]                 start_heading;
    logic [HEAD_W-1:0]                 prev_heading;
    logic signed [WRAP_COUNT_BITS-1:0] wrap_count;
    logic [SPEED_W-1:0]                speed;
    logic signed [PEAK_W-1:0]          peak_speed;
    logic [LIMIT_W-1:0]                speed_limit;
    logic                              high_gain;
    logic                              finished;
  } state_t;

  // one result item
  typedef struct packed {
    logic signed [TURN_OUT_W-1:0] turned_angle;
    logic                         turn_done;
    logic signed [WHEEL_W-1:0]    right_speed;
    logic signed [WHEEL_W-1:0]    left_speed;
  } result_t;

endpackage

[hw/rtl/tspc_core.sv]
module tspc_core (
  input  tspc_pkg::op_t                      op,
  input  logic [tspc_pkg::HEAD_W-1:0]        heading,
  input  logic signed [tspc_pkg::TGT_W-1:0]  target_angle,
  input  logic [tspc_pkg::STEP_W-1:0]        ramp_step,
  input  tspc_pkg::state_t                   st,
  output tspc_pkg::state_t                   st_nxt,
  output tspc_pkg::result_t                  res
);

  localparam int CW = tspc_pkg::CMP_W;
  localparam int SF = tspc_pkg::SPEED_FRAC;
  localparam int AF = tspc_pkg::ANGLE_FRACTION_BITS;
  localparam int WB = tspc_pkg::WRAP_COUNT_BITS;

  localparam logic signed [CW-1:0] C_DEG1   = CW'(tspc_pkg::DEG1);
  localparam logic signed [CW-1:0] C_DEG90  = CW'(tspc_pkg::DEG90);
  localparam logic signed [CW-1:0] C_DEG180 = CW'(tspc_pkg::DEG180);
  localparam logic signed [CW-1:0] C_DEG340 = CW'(tspc_pkg::DEG340);
  localparam logic signed [CW-1:0] C_DEG360 = CW'(tspc_pkg::DEG360);
  localparam logic signed [WB-1:0] WRAP_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] WRAP_MIN = {1'b1, {(WB-1){1'b0}}};

  logic signed [CW-1:0] tgt_x;
  logic signed [CW-1:0] tabs;
  logic signed [CW-1:0] diff;
  logic signed [WB-1:0] wrap;
  logic signed [CW-1:0] wrap_x;
  logic signed [CW-1:0] turned;
  logic signed [CW-1:0] tnabs;
  logic signed [CW-1:0] lim16;
  logic signed [CW-1:0] err;
  logic signed [CW-1:0] err_g;
  logic signed [CW-1:0] s;
  logic [tspc_pkg::SPEED_W-1:0] spd;
  logic [tspc_pkg::WHEEL_W-1:0] mag;

  always_comb begin
    // absolute target
    tgt_x = CW'(target_angle);
    tabs  = (tgt_x < 0) ? -tgt_x : tgt_x;

    st_nxt = st;
    res    = '0;
    wrap   = st.wrap_count;
    wrap_x = '0;
    turned = '0;
    tnabs  = '0;
    lim16  = '0;
    err    = '0;
    err_g  = '0;
    s      = '0;
    diff   = '0;
    spd    = '0;
    mag    = '0;

    if (op == tspc_pkg::OP_START) begin
      // capture heading and pick profile from target size
      st_nxt.start_heading = heading;
      st_nxt.prev_heading  = heading;
      st_nxt.wrap_count    = '0;
      st_nxt.speed         = '0;
      st_nxt.peak_speed    = tspc_pkg::PEAK_W'(tspc_pkg::PEAK_RESET);
      st_nxt.finished      = 1'b0;
      if (tabs >= C_DEG180) begin
        st_nxt.speed_limit = tspc_pkg::LIMIT_W'(tspc_pkg::LIMIT_HI);
        st_nxt.high_gain   = 1'b1;
      end else if (tabs >= C_DEG90) begin
        st_nxt.speed_limit = tspc_pkg::LIMIT_W'(tspc_pkg::LIMIT_MID);
        st_nxt.high_gain   = 1'b0;
      end else begin
        st_nxt.speed_limit = tspc_pkg::LIMIT_W'(tspc_pkg::LIMIT_LO);
        st_nxt.high_gain   = 1'b0;
      end
    end else begin
      // heading unwrap with saturating wrap count
      diff = CW'(heading) - CW'(st.prev_heading);
      if (diff < -C_DEG340) begin
        if (wrap != WRAP_MAX) wrap = wrap + WB'(1);
      end else if (diff > C_DEG340) begin
        if (wrap != WRAP_MIN) wrap = wrap - WB'(1);
      end
      st_nxt.wrap_count   = wrap;
      st_nxt.prev_heading = heading;

      wrap_x = CW'(wrap);
      turned = CW'(heading) + wrap_x * C_DEG360 - CW'(st.start_heading);
      tnabs  = (turned < 0) ? -turned : turned;
      lim16  = CW'(st.speed_limit) <<< SF;

      if (st.finished) begin
        st_nxt.speed = '0;
      end else begin
        if ((tnabs <<< 1) < tabs) begin
          // acceleration phase, peak follows the ramp
          s = CW'(st.speed) + (CW'(ramp_step) <<< SF);
          st_nxt.peak_speed = tspc_pkg::PEAK_W'(s);
        end else begin
          // proportional slowdown capped at the peak
          err = tabs - tnabs;
          if (err <= 0) begin
            s = '0;
          end else begin
            err_g = st.high_gain ? (err + (err <<< 1)) : (err <<< 1);
            s = (err_g <<< (SF - 1)) >>> AF;
          end
          if (s > CW'(st.peak_speed)) s = CW'(st.peak_speed);
        end
        if (s > lim16) s = lim16;
        else if (s < 0) s = '0;
        st_nxt.speed = tspc_pkg::SPEED_W'(s);
        if ((tnabs > tabs - C_DEG1) && (s == 0)) st_nxt.finished = 1'b1;
      end

      // wheel commands in whole rpm, opposite signs
      spd = st_nxt.speed;
      mag = tspc_pkg::WHEEL_W'(spd >> SF);
      if (target_angle < 0) begin
        res.left_speed  = -$signed(mag);
        res.right_speed = $signed(mag);
      end else begin
        res.left_speed  = $signed(mag);
        res.right_speed = -$signed(mag);
      end
      res.turn_done    = st_nxt.finished;
      res.turned_angle = turned[tspc_pkg::TURN_OUT_W-1:0];
    end
  end

endmodule

[hw/rtl/turn_speed_profile_controller.sv]
// Point-turn speed profiler: a start transfer (tuser 0) latches the heading and picks
// the speed limit and gain from the target angle; each tick transfer (tuser 1) unwraps
// the heading and returns left/right wheel commands, the done flag and the angle turned.
// Every input transfer gives exactly one result transfer. An item passes an input
// register and the controller logic into the output register, and its result is offered
// once the output register has taken it. One item per cycle is sustained while the
// result side is ready, and the controller state is updated when an item moves from
// that logic into the output register. Configuration writes take effect on the next cycle;
// the user must make them while the block is idle, which the block itself does not enforce.
`include "assert_macros.svh"

module turn_speed_profile_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [tspc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [tspc_pkg::TGT_W-1:0]        cfg_wdata,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // heading[12:0], zero pad
  input  logic                              in_tuser,   // operation
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [39:0]                       out_tdata   // left_speed[8:0], right_speed[17:9],
                                                        // turn_done[18], turned_angle[39:19]
);

  logic signed [tspc_pkg::TGT_W-1:0]  target_r;
  logic [tspc_pkg::STEP_W-1:0]        step_r;
  tspc_pkg::state_t                   st_r;
  tspc_pkg::state_t                   st_nxt;
  logic                               s1_valid_r;
  tspc_pkg::op_t                      s1_op_r;
  logic [tspc_pkg::HEAD_W-1:0]        s1_head_r;
  logic                               out_valid_r;
  tspc_pkg::result_t                  out_res_r;
  tspc_pkg::result_t                  res;
  logic                               out_free;
  logic                               s1_adv;
  logic                               in_xfer;

  // handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      step_r   <= tspc_pkg::STEP_W'(tspc_pkg::STEP_RESET);
    end else if (cfg_we) begin
      unique case (tspc_pkg::cfg_idx_t'(cfg_addr))
        tspc_pkg::REG_TARGET_ANGLE: target_r <= $signed(cfg_wdata);
        tspc_pkg::REG_RAMP_STEP:    step_r   <= cfg_wdata[tspc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= tspc_pkg::op_t'(in_tuser);
      s1_head_r <= in_tdata[tspc_pkg::HEAD_W-1:0];
    end
  end

  tspc_core u_core (
    .op           (s1_op_r),
    .heading      (s1_head_r),
    .target_angle (target_r),
    .ramp_step    (step_r),
    .st           (st_r),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.start_heading <= '0;
      st_r.prev_heading  <= '0;
      st_r.wrap_count    <= '0;
      st_r.speed         <= '0;
      st_r.peak_speed    <= tspc_pkg::PEAK_W'(tspc_pkg::PEAK_RESET);
      st_r.speed_limit   <= tspc_pkg::LIMIT_W'(tspc_pkg::LIMIT_LO);
      st_r.high_gain     <= 1'b0;
      st_r.finished      <= 1'b0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  // a finished turn reports zero wheel speed
  `ASSERT_IMPL(a_done_zero, clk, rst_n,
    out_valid_r && out_res_r.turn_done,
    out_res_r.left_speed == '0, "done with nonzero speed")

  // wheels always turn in opposite directions
  `ASSERT_IMPL(a_opposite, clk, rst_n, out_valid_r,
    out_res_r.right_speed == -out_res_r.left_speed, "wheel speeds not opposite")

  // done stays set across ticks
  `ASSERT_NEXT(a_done_sticky, clk, rst_n,
    s1_adv && (s1_op_r == tspc_pkg::OP_TICK) && st_r.finished,
    st_r.finished, "done flag dropped on tick")

  // speed never exceeds the chosen limit
  `ASSERT_IMPL(a_speed_lim, clk, rst_n, 1'b1,
    st_r.speed <= (tspc_pkg::SPEED_W'(st_r.speed_limit) << tspc_pkg::SPEED_FRAC),
    "speed above limit")

endmodule

[tb/sv/turn_profile_checker.sv]
module turn_profile_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tspc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tspc_pkg::TGT_W-1:0]     cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // heading[12:0], zero pad
  input  logic                           in_tuser,   // operation
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [39:0]                    out_tdata,  // left_speed, right_speed, turn_done,
                                                     // turned_angle
  output int                             mismatches,
  output int                             awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import tspc_pkg::*;

  localparam int WRAP_TOP = (1 << (WRAP_COUNT_BITS - 1)) - 1;
  localparam int WRAP_BOTTOM = -WRAP_TOP - 1;

  // register copies
  logic signed [TGT_W-1:0]           target_reg;
  logic [STEP_W-1:0]                 step_reg;

  // controller state as the block should hold it
  logic [HEAD_W-1:0]                 origin_heading;
  logic [HEAD_W-1:0]                 last_heading;
  logic signed [WRAP_COUNT_BITS-1:0] wraps;
  int                                wheel_speed;
  int                                peak;
  int                                limit;
  bit                                boosted;
  bit                                settled;

  result_t                           pending_commands[$];
  result_t                           seen;
  result_t                           want;

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] exp);
    if (got !== exp)
      flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp));
  endtask

  // wheel command for one item, advancing the controller state
  function automatic result_t predict_command(op_t op, logic [HEAD_W-1:0] hd);
    result_t r;
    longint  goal;
    longint  diff;
    longint  turned;
    longint  span;
    longint  cap;
    longint  s;
    longint  err;
    longint  left;
    longint  right;
    r = '0;
    goal = (target_reg < 0) ? -longint'(target_reg) : longint'(target_reg);

    // start: latch heading, pick limit and gain from target size
    if (op == OP_START) begin
      origin_heading = hd;
      last_heading = hd;
      wraps = '0;
      wheel_speed = 0;
      peak = PEAK_RESET;
      settled = 1'b0;
      if (goal >= DEG180) begin
        limit = LIMIT_HI;
        boosted = 1'b1;
      end else if (goal >= DEG90) begin
        limit = LIMIT_MID;
        boosted = 1'b0;
      end else begin
        limit = LIMIT_LO;
        boosted = 1'b0;
      end
      return r;
    end

    // heading unwrap with saturating wrap count
    diff = longint'(hd) - longint'(last_heading);
    if (diff < -DEG340) begin
      if (int'(wraps) < WRAP_TOP) wraps++;
    end else if (diff > DEG340) begin
      if (int'(wraps) > WRAP_BOTTOM) wraps--;
    end
    last_heading = hd;
    turned = longint'(hd) + longint'(wraps) * DEG360 - longint'(origin_heading);
    span = (turned < 0) ? -turned : turned;
    cap = longint'(limit) << SPEED_FRAC;

    if (settled) begin
      wheel_speed = 0;
    end else begin
      // ramp up over the first half, proportional slowdown after
      if (2 * span < goal) begin
        s = longint'(wheel_speed) + (longint'(step_reg) << SPEED_FRAC);
        peak = int'(s);
      end else begin
        err = goal - span;
        if (err <= 0)
          s = 0;
        else
          s = (err * (boosted ? 3 : 2) * (longint'(1) << (SPEED_FRAC - 1)))
              >>> ANGLE_FRACTION_BITS;
        if (s > peak) s = peak;
      end
      if (s > cap) s = cap;
      else if (s < 0) s = 0;
      wheel_speed = int'(s);
      if (span > goal - DEG1 && wheel_speed == 0) settled = 1'b1;
    end

    left = longint'(wheel_speed) >>> SPEED_FRAC;
    if (target_reg < 0) left = -left;
    right = -left;
    r.left_speed = left[WHEEL_W-1:0];
    r.right_speed = right[WHEEL_W-1:0];
    r.turn_done = settled;
    r.turned_angle = turned[TURN_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      target_reg = '0;
      step_reg = STEP_W'(STEP_RESET);
      origin_heading = '0;
      last_heading = '0;
      wraps = '0;
      wheel_speed = 0;
      peak = PEAK_RESET;
      limit = LIMIT_LO;
      boosted = 1'b0;
      settled = 1'b0;
      pending_commands.delete();
      mismatches = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_TARGET_ANGLE: target_reg = cfg_wdata;
          REG_RAMP_STEP:    step_reg = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end

      // result transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (pending_commands.size() == 0) begin
          flag_mismatch($sformatf("result %h with nothing outstanding", out_tdata));
        end else begin
          want = pending_commands.pop_front();
          check_field("left_speed", seen.left_speed, want.left_speed);
          check_field("right_speed", seen.right_speed, want.right_speed);
          check_field("turn_done", seen.turn_done, want.turn_done);
          check_field("turned_angle", seen.turned_angle, want.turned_angle);
        end
      end

      // input transfer
      if (in_tvalid && in_tready)
        pending_commands.push_back(predict_command(op_t'(in_tuser), in_tdata[HEAD_W-1:0]));
    end
    awaiting = pending_commands.size();
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tspc_pkg::*;

  localparam int ITEM_GOAL = 1950;
  localparam int WRAP_TOP = (1 << (WRAP_COUNT_BITS - 1)) - 1;
  localparam int HOLD_CYCLES = 64;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [TGT_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [39:0]          out_tdata;
  int                   mismatches;
  int                   awaiting;

  bit                   steady;
  int                   squeeze_asked;
  int                   squeeze_done;
  int                   sent;
  int                   heading_now;

  int notable_targets[11] = '{0, 1439, 1440, 2879, 2880, 16, -16,
                              57600, -57600, 65535, -65536};

  turn_speed_profile_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  turn_profile_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #10 clk = ~clk;

  // one input transfer, with random gaps in front of it
  task automatic send_item(op_t op, int hd);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 15) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, hd[HEAD_W-1:0]};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value[TGT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // small, mid and large turns, some at the limit thresholds, a few very large
  function automatic int pick_target();
    int mag;
    int r;
    r = $urandom_range(99);
    if (r < 20) return notable_targets[$urandom_range(10)];
    if (r < 50) mag = $urandom_range(DEG90 - 1);
    else if (r < 75) mag = $urandom_range(DEG180 - 1, DEG90);
    else if (r < 93) mag = $urandom_range(8000, DEG180);
    else mag = $urandom_range(57600, 8000);
    return ($urandom_range(1) == 1) ? -mag : mag;
  endfunction

  // heading moves towards the target, overshoots a little, with some noise
  task automatic run_turn(int target, bit fresh);
    int mag;
    int dir;
    int stride;
    int travelled;
    int step;
    int extra;
    mag = (target < 0) ? -target : target;
    dir = (target < 0) ? -1 : 1;
    stride = mag / 10;
    if (stride < 4) stride = 4;
    else if (stride > 300) stride = 300;
    if (fresh) begin
      heading_now = $urandom_range(DEG360 - 1);
      send_item(OP_START, heading_now);
    end
    travelled = 0;
    extra = $urandom_range(6, 2);
    while (travelled < mag || extra > 0) begin
      if (travelled >= mag) begin
        extra--;
        step = $urandom_range(20);
      end else begin
        step = $urandom_range(stride);
      end
      if ($urandom_range(9) == 0) step = 0 - int'($urandom_range(stride / 2));
      travelled += step;
      heading_now = ((heading_now + dir * step) % DEG360 + DEG360) % DEG360;
      if ($urandom_range(99) < 6)
        send_item(op_t'($urandom_range(1)), int'($urandom_range(8191)));
      else
        send_item(OP_TICK, heading_now);
    end
  endtask

  // repeated full-circle jumps to drive the wrap count into saturation
  task automatic spin_heading(bit upward);
    int top_h;
    send_item(OP_START, 0);
    repeat (WRAP_TOP + 8) begin
      top_h = ($urandom_range(3) == 0) ? 8191 : DEG360 - 1;
      send_item(OP_TICK, 2880);
      if (upward) begin
        send_item(OP_TICK, top_h);
        send_item(OP_TICK, 0);
      end else begin
        send_item(OP_TICK, 0);
        send_item(OP_TICK, top_h);
      end
    end
    heading_now = upward ? 0 : DEG360 - 1;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze_done < squeeze_asked) begin
        squeeze_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase;
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    steady = 1'b0;
    squeeze_asked = 0;
    squeeze_done = 0;
    sent = 0;
    heading_now = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // ticks from the reset state, out-of-range heading, both unwrap directions
    send_item(OP_TICK, 0);
    send_item(OP_TICK, 8191);
    send_item(OP_START, DEG360 - 1);
    send_item(OP_TICK, 0);
    send_item(OP_TICK, DEG360 - 1);

    // half-circle turn at the fastest ramp
    settle();
    write_reg(REG_TARGET_ANGLE, DEG180);
    write_reg(REG_RAMP_STEP, 15);
    send_item(OP_START, 100);
    for (int i = 1; i <= 6; i++) send_item(OP_TICK, 100 + i * 300);

    // target changed mid-turn, direction flips
    settle();
    write_reg(REG_TARGET_ANGLE, -1000);
    send_item(OP_TICK, 2200);
    send_item(OP_TICK, 2500);

    // large negative target, no ramp
    settle();
    write_reg(REG_TARGET_ANGLE, -57600);
    write_reg(REG_RAMP_STEP, 0);
    send_item(OP_START, 0);
    send_item(OP_TICK, DEG360 - 1);

    // just under the mid threshold, through the target and past it
    settle();
    write_reg(REG_TARGET_ANGLE, DEG90 - 1);
    write_reg(REG_RAMP_STEP, 1);
    send_item(OP_START, 3000);
    send_item(OP_TICK, 3700);
    send_item(OP_TICK, 3000 + DEG90 - 1);
    send_item(OP_TICK, 3000 + DEG90 + 10);
    send_item(OP_TICK, 4500);

    // random phases of turns with fresh register settings
    phase = 0;
    while (sent < ITEM_GOAL) begin
      settle();
      steady = (phase >= 6 && phase < 10);
      target = (phase == 4 || phase == 14) ? -DEG180 : pick_target();
      write_reg(REG_TARGET_ANGLE, target);
      if ($urandom_range(1) == 1) begin
        if ($urandom_range(4) == 0)
          write_reg(REG_RAMP_STEP, ($urandom_range(1) == 1) ? 15 : 0);
        else
          write_reg(REG_RAMP_STEP, $urandom_range(15));
      end
      if (phase == 2) begin
        spin_heading(1'b1);
      end else if (phase == 9) begin
        spin_heading(1'b0);
      end else begin
        if (phase == 4 || phase == 14) squeeze_asked++;
        repeat ($urandom_range(2, 1)) run_turn(target, $urandom_range(99) < 85);
      end
      phase++;
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
